// File: hdl/dfe_pkg.sv
// Shared types, constants and frame helpers for the DShot frame encoder.
package dfe_pkg;

    localparam int FRAME_BITS = 16;
    localparam int VALUE_W = 11;
    localparam int DUTY_W = 16;
    localparam int SLOT_W = 5;
    localparam int MAX_MOTORS = 4;
    localparam logic [VALUE_W-1:0] THROTTLE_OFFSET = 11'd48;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 11'd2047;
    localparam logic [DUTY_W-1:0] BIT_PERIOD_RESET = 16'd1120;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] throttle_0;
        logic [VALUE_W-1:0] throttle_1;
        logic [VALUE_W-1:0] throttle_2;
        logic [VALUE_W-1:0] throttle_3;
        logic [VALUE_W-1:0] command_code;
    } t_in;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_0;
        logic [DUTY_W-1:0] duty_1;
        logic [DUTY_W-1:0] duty_2;
        logic [DUTY_W-1:0] duty_3;
        logic [SLOT_W-1:0] slot_index;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [DUTY_W-1:0] zero;
        logic [DUTY_W-1:0] one;
    } t_duty;

    function automatic logic [VALUE_W-1:0] map_throttle(input logic [VALUE_W-1:0] t);
        logic [VALUE_W:0] sum;
        sum = {1'b0, t} + {1'b0, THROTTLE_OFFSET};
        if (t == '0) begin
            return '0;
        end else if (sum[VALUE_W]) begin
            return VALUE_MAX;
        end
        return sum[VALUE_W-1:0];
    endfunction

    function automatic logic [FRAME_BITS-1:0] build_frame(input logic [VALUE_W-1:0] v);
        logic [VALUE_W:0] word;
        logic [3:0]       csum;
        word = {v, 1'b0};
        csum = word[3:0] ^ word[7:4] ^ word[11:8];
        return {word, csum};
    endfunction

endpackage

// File: hdl/dfe_front.sv
// Front end: accepts input items and turns them into per-motor 16-bit frames.
module dfe_front import dfe_pkg::*; #(
    parameter int MOTORS = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  t_in                                  i_data,
    output logic                                 o_push,
    output logic [MOTORS-1:0][FRAME_BITS-1:0]    o_frames,
    input  logic                                 i_full
);

    logic                              r_valid;
    logic [MOTORS-1:0][FRAME_BITS-1:0] r_frames;
    logic [MOTORS-1:0][FRAME_BITS-1:0] n_frames;
    logic [MAX_MOTORS-1:0][VALUE_W-1:0] thr;
    logic                              advance;

    assign thr = {i_data.throttle_3, i_data.throttle_2, i_data.throttle_1, i_data.throttle_0};

    for (genvar m = 0; m < MOTORS; m++) begin : g_motor
        assign n_frames[m] = build_frame(i_data.mode ? map_throttle(thr[m])
                                                     : i_data.command_code);
    end

    assign advance  = !r_valid || !i_full;
    assign o_stall  = !advance;
    assign o_push   = r_valid && !i_full;
    assign o_frames = r_frames;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_valid;
        end
        if (advance && i_valid) begin
            r_frames <= n_frames;
        end
    end

endmodule

// File: hdl/dfe_fifo.sv
// Two-entry queue that decouples the frame builder from the slot sequencer.
module dfe_fifo #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_avail,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_full  = r_count == 2'd2;
    assign o_avail = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/dfe_back.sv
// Back end: walks each queued frame set through its slots and registers the results.
module dfe_back import dfe_pkg::*; #(
    parameter int SLOTS  = 18,
    parameter int MOTORS = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_duty                             i_duty,
    input  logic                              i_avail,
    input  logic [MOTORS-1:0][FRAME_BITS-1:0] i_frames,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output t_out                              o_data
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W-1:0] GAP_START = SLOT_W'(FRAME_BITS);

    logic                              r_busy;
    logic [SLOT_W-1:0]                 r_slot;
    logic [MOTORS-1:0][FRAME_BITS-1:0] r_frames;
    logic                              r_valid;
    t_out                              r_out;

    logic                              advance;
    logic                              emit;
    logic [SLOT_W-1:0]                 cur_slot;
    logic [MOTORS-1:0][FRAME_BITS-1:0] cur_frames;
    logic [MAX_MOTORS-1:0][DUTY_W-1:0] duty;
    logic                              in_frame;
    t_out                              n_out;

    assign advance    = !r_valid || !i_stall;
    assign o_pop      = advance && !r_busy && i_avail;
    assign emit       = advance && (r_busy || i_avail);
    assign cur_slot   = r_busy ? r_slot : '0;
    assign cur_frames = r_busy ? r_frames : i_frames;
    assign in_frame   = cur_slot < GAP_START;

    for (genvar m = 0; m < MAX_MOTORS; m++) begin : g_duty
        if (m < MOTORS) begin : g_used
            assign duty[m] = !in_frame ? '0 :
                             (cur_frames[m][FRAME_BITS-1] ? i_duty.one : i_duty.zero);
        end else begin : g_unused
            assign duty[m] = '0;
        end
    end

    always_comb begin
        n_out.duty_0     = duty[0];
        n_out.duty_1     = duty[1];
        n_out.duty_2     = duty[2];
        n_out.duty_3     = duty[3];
        n_out.slot_index = cur_slot;
        n_out.last       = cur_slot == LAST_SLOT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= emit;
            if (emit) begin
                r_busy <= cur_slot != LAST_SLOT;
                r_slot <= cur_slot + SLOT_W'(1);
            end
        end
        if (emit) begin
            r_out <= n_out;
            for (int m = 0; m < MOTORS; m++) begin
                r_frames[m] <= {cur_frames[m][FRAME_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

`ifndef NO_ASSERTIONS
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last |-> o_data.slot_index == LAST_SLOT)
        else $error("last flag on a slot other than the final one");
    a_gap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.slot_index >= GAP_START |->
        o_data.duty_0 == '0 && o_data.duty_1 == '0 &&
        o_data.duty_2 == '0 && o_data.duty_3 == '0)
        else $error("nonzero duty in a gap slot");
    a_busy_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_slot != '0)
        else $error("sequencer busy at slot zero");
    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_avail && !r_busy)
        else $error("pop from an empty queue or during a frame");
`endif

endmodule

// File: hdl/dshot_frame_encoder_top.sv
// Top level of the DShot frame encoder: configuration register, front end, queue, back end.
// Each accepted item yields SLOTS results (18 by default), emitted by the slot sequencer one
// per clock while the output is not stalled. Items pass through a registered frame builder
// and a two-entry queue, so new items are taken while a frame is still being sent.
// Duty values are 3/8 and 3/4 of bit_period, rounded down; write bit_period only while
// the block is idle. The configuration port is always ready.
module dshot_frame_encoder_top import dfe_pkg::*; #(
    parameter int SLOTS  = 18,
    parameter int MOTORS = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in               i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out              o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [DUTY_W-1:0] i_cfg_data
);

    localparam int QW = MOTORS * FRAME_BITS;

    logic [DUTY_W-1:0]                 r_bit_period;
    logic [DUTY_W+1:0]                 period_x3;
    t_duty                             duty;
    logic                              push;
    logic                              full;
    logic                              pop;
    logic                              avail;
    logic [MOTORS-1:0][FRAME_BITS-1:0] front_frames;
    logic [MOTORS-1:0][FRAME_BITS-1:0] head_frames;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bit_period <= i_cfg_data;
        end
    end

    assign period_x3 = {2'b00, r_bit_period} + {1'b0, r_bit_period, 1'b0};
    assign duty.zero = {1'b0, period_x3[DUTY_W+1:3]};
    assign duty.one  = period_x3[DUTY_W+1:2];

    dfe_front #(.MOTORS(MOTORS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_data   (i_data),
        .o_push   (push),
        .o_frames (front_frames),
        .i_full   (full)
    );

    dfe_fifo #(.WIDTH(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_frames),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_data  (head_frames)
    );

    dfe_back #(.SLOTS(SLOTS), .MOTORS(MOTORS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_duty   (duty),
        .i_avail  (avail),
        .i_frames (head_frames),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

endmodule
